[rtl/bdar_pkg.sv]
// ----------------------------------------------------------------------------
// bdar_pkg
// Shared types and constants for the button-driven axis ramp.
// ----------------------------------------------------------------------------
package bdar_pkg;

  // field widths
  localparam int unsigned PosW    = 32;
  localparam int unsigned SpeedW  = 25;
  localparam int unsigned DtW     = 20;
  localparam int unsigned ProdW   = (SpeedW - 1) + DtW;
  localparam int unsigned CapW    = ProdW - 16;
  localparam int unsigned CfgIdxW = 3;

  // default range, -1.0 .. 1.0 in Q15.16
  localparam logic signed [PosW-1:0]   DefaultMin = 32'shFFFF_0000;
  localparam logic signed [PosW-1:0]   DefaultMax = 32'sh0001_0000;
  // speed reset value, -1 means jump
  localparam logic signed [SpeedW-1:0] SpeedReset = 25'h1FF_FFFF;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_AXIS_MIN       = 3'd0,
    CFG_AXIS_MAX       = 3'd1,
    CFG_POSITIVE_SPEED = 3'd2,
    CFG_NEGATIVE_SPEED = 3'd3,
    CFG_CENTER_SPEED   = 3'd4,
    CFG_REST_SPEED     = 3'd5
  } cfg_idx_e;

  // ramp target kind
  typedef enum logic [1:0] {
    MODE_MID   = 2'd0,
    MODE_PLUS  = 2'd1,
    MODE_MINUS = 2'd2
  } mode_e;

  // effective configuration seen by the datapath
  typedef struct packed {
    logic signed [PosW-1:0]   lo;
    logic signed [PosW-1:0]   hi;
    logic signed [PosW-1:0]   mid;
    logic signed [SpeedW-1:0] positive_speed;
    logic signed [SpeedW-1:0] negative_speed;
    logic signed [SpeedW-1:0] center_speed;
    logic signed [SpeedW-1:0] rest_speed;
  } cfg_t;

endpackage

[rtl/button_driven_axis_ramp_core.sv]
// ----------------------------------------------------------------------------
// button_driven_axis_ramp_core
// Slew-rate-limited axis position driven by plus, minus and center buttons.
// ----------------------------------------------------------------------------
// pipeline: decode/multiply stage, then position update stage, from input
//   transaction to result valid
// throughput: 1 transaction per cycle while the output is not stalled; the
//   position feedback closes in one compare-and-add stage
// reset: position 0, range -1.0 .. 1.0, all speeds -1 (jump), pipeline empty
module button_driven_axis_ramp_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input ticks
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // plus_pressed[0], minus_pressed[1], center_pressed[2], elapsed_time[22:3]
  input  logic [23:0]                  s_axis_tdata,
  // results
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // axis_position[31:0], at_target[32]
  output logic [39:0]                  m_axis_tdata,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [bdar_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bdar_pkg::PosW-1:0]    cfg_wdata_i
);

  bdar_pkg::cfg_t cfg;

  bdar_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input field unpacking
  logic                          in_plus, in_minus, in_center;
  logic [bdar_pkg::DtW-1:0]      in_dt;
  assign in_plus   = s_axis_tdata[0];
  assign in_minus  = s_axis_tdata[1];
  assign in_center = s_axis_tdata[2];
  assign in_dt     = s_axis_tdata[22:3];

  // handshake
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_ready, s1_adv, in_acc;

  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_ready;
  assign s_axis_tready = !s1_valid_q || out_ready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // mode decode: center wins, plus and minus together cancel
  bdar_pkg::mode_e               mode_d;
  logic signed [bdar_pkg::SpeedW-1:0] speed;
  logic signed [bdar_pkg::PosW-1:0]   target_d;

  always_comb begin
    if (in_center) begin
      mode_d = bdar_pkg::MODE_MID;
      speed  = cfg.center_speed;
    end else if (in_plus && !in_minus) begin
      mode_d = bdar_pkg::MODE_PLUS;
      speed  = cfg.positive_speed;
    end else if (in_minus && !in_plus) begin
      mode_d = bdar_pkg::MODE_MINUS;
      speed  = cfg.negative_speed;
    end else begin
      mode_d = bdar_pkg::MODE_MID;
      speed  = cfg.rest_speed;
    end
  end

  always_comb begin
    case (mode_d)
      bdar_pkg::MODE_PLUS:  target_d = cfg.hi;
      bdar_pkg::MODE_MINUS: target_d = cfg.lo;
      default:              target_d = cfg.mid;
    endcase
  end

  // step cap, speed times elapsed time in Q16
  logic [bdar_pkg::ProdW-1:0] prod;
  assign prod = {{bdar_pkg::DtW{1'b0}}, speed[bdar_pkg::SpeedW-2:0]}
              * {{(bdar_pkg::SpeedW-1){1'b0}}, in_dt};

  // decode stage registers
  bdar_pkg::mode_e                  s1_mode_q;
  logic                             s1_jump_q;
  logic [bdar_pkg::CapW-1:0]        s1_cap_q;
  logic signed [bdar_pkg::PosW-1:0] s1_target_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_mode_q   <= mode_d;
      s1_jump_q   <= speed[bdar_pkg::SpeedW-1];
      s1_cap_q    <= prod[bdar_pkg::ProdW-1:16];
      s1_target_q <= target_d;
    end
  end

  // position update
  logic signed [bdar_pkg::PosW-1:0] pos_q, pos_d;
  logic                             at_target_q;
  logic                             down, capped;
  logic signed [bdar_pkg::PosW:0]   delta;
  logic [bdar_pkg::PosW-1:0]        step;

  // in mid mode, at or below the midpoint the position moves upward
  assign down = (s1_mode_q == bdar_pkg::MODE_MINUS)
             || ((s1_mode_q == bdar_pkg::MODE_MID) && (pos_q > s1_target_q));

  // signed distance; negative when already past the target, then no cap
  assign delta = down
    ? ({pos_q[bdar_pkg::PosW-1], pos_q} - {s1_target_q[bdar_pkg::PosW-1], s1_target_q})
    : ({s1_target_q[bdar_pkg::PosW-1], s1_target_q} - {pos_q[bdar_pkg::PosW-1], pos_q});

  assign capped = !s1_jump_q
               && (delta > $signed({{(bdar_pkg::PosW + 1 - bdar_pkg::CapW){1'b0}}, s1_cap_q}));
  assign step   = {{(bdar_pkg::PosW - bdar_pkg::CapW){1'b0}}, s1_cap_q};

  // a capped step stops short of the target and does not pass it, so never overflows
  always_comb begin
    if (!capped) begin
      pos_d = s1_target_q;
    end else if (down) begin
      pos_d = pos_q - $signed(step);
    end else begin
      pos_d = pos_q + $signed(step);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  // position doubles as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pos_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        pos_q <= pos_d;
      end
    end
  end

  // uncapped step always ends on the target, a capped one never does
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      at_target_q <= !capped;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, at_target_q, pos_q};

endmodule

[rtl/bdar_cfg_regs.sv]
// ----------------------------------------------------------------------------
// bdar_cfg_regs
// Configuration registers with range fallback and midpoint computation.
// ----------------------------------------------------------------------------
module bdar_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bdar_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [bdar_pkg::PosW-1:0]        cfg_wdata_i,
  output bdar_pkg::cfg_t                   cfg_o
);

  logic signed [bdar_pkg::PosW-1:0]   min_q, max_q;
  logic signed [bdar_pkg::SpeedW-1:0] pos_speed_q, neg_speed_q, ctr_speed_q, rest_speed_q;
  logic signed [bdar_pkg::PosW-1:0]   lo, hi;
  logic signed [bdar_pkg::PosW:0]     mid_sum;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q        <= bdar_pkg::DefaultMin;
      max_q        <= bdar_pkg::DefaultMax;
      pos_speed_q  <= bdar_pkg::SpeedReset;
      neg_speed_q  <= bdar_pkg::SpeedReset;
      ctr_speed_q  <= bdar_pkg::SpeedReset;
      rest_speed_q <= bdar_pkg::SpeedReset;
    end else if (cfg_we_i) begin
      unique case (bdar_pkg::cfg_idx_e'(cfg_idx_i))
        bdar_pkg::CFG_AXIS_MIN:       min_q        <= cfg_wdata_i;
        bdar_pkg::CFG_AXIS_MAX:       max_q        <= cfg_wdata_i;
        bdar_pkg::CFG_POSITIVE_SPEED: pos_speed_q  <= cfg_wdata_i[bdar_pkg::SpeedW-1:0];
        bdar_pkg::CFG_NEGATIVE_SPEED: neg_speed_q  <= cfg_wdata_i[bdar_pkg::SpeedW-1:0];
        bdar_pkg::CFG_CENTER_SPEED:   ctr_speed_q  <= cfg_wdata_i[bdar_pkg::SpeedW-1:0];
        bdar_pkg::CFG_REST_SPEED:     rest_speed_q <= cfg_wdata_i[bdar_pkg::SpeedW-1:0];
        default: ;
      endcase
    end
  end

  // empty or inverted range falls back to the default range
  always_comb begin
    if (min_q >= max_q) begin
      lo = bdar_pkg::DefaultMin;
      hi = bdar_pkg::DefaultMax;
    end else begin
      lo = min_q;
      hi = max_q;
    end
  end

  // midpoint, rounded toward minus infinity
  assign mid_sum = {lo[bdar_pkg::PosW-1], lo} + {hi[bdar_pkg::PosW-1], hi};

  assign cfg_o.lo             = lo;
  assign cfg_o.hi             = hi;
  assign cfg_o.mid            = mid_sum[bdar_pkg::PosW:1];
  assign cfg_o.positive_speed = pos_speed_q;
  assign cfg_o.negative_speed = neg_speed_q;
  assign cfg_o.center_speed   = ctr_speed_q;
  assign cfg_o.rest_speed     = rest_speed_q;

endmodule

[rtl/bdar_checker.sv]
// ----------------------------------------------------------------------------
// bdar_checker
// Port-level assertions for the button-driven axis ramp, bound to the top.
// ----------------------------------------------------------------------------
module bdar_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // a free output side never blocks the input side
  a_ready_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output side ready");

  // an accepted transaction passes the decode stage and shows up once the output drains
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing after accepted transaction");

  // no result while in reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind button_driven_axis_ramp_core bdar_checker u_bdar_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
